@@ design/two_stack_bubble_sort_assert.svh @@
// Assertion shorthands for the two-stack sorter.
// Each macro expands to one labeled concurrent assertion, sampled on the
// rising clock edge and disabled while reset is asserted.
`ifndef TWO_STACK_BUBBLE_SORT_ASSERT_SVH
`define TWO_STACK_BUBBLE_SORT_ASSERT_SVH

// Same-cycle implication.
`define TSBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tsbs_pkg.sv @@
package tsbs_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 8;

    // One stored record: key above tag
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
    } rec_t;

endpackage

@@ design/tsbs_in_if.sv @@
interface tsbs_in_if
    import tsbs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic                    last;

    modport source (output valid, output key, output tag, output last, input ready);
    modport sink (input valid, input key, input tag, input last, output ready);
endinterface

@@ design/tsbs_out_if.sv @@
interface tsbs_out_if
    import tsbs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] key_res;
    logic        [TAG_W-1:0] tag_res;
    logic                    last_res;
    logic                    overflow;

    modport source (output valid, output key_res, output tag_res, output last_res,
                    output overflow, input ready);
    modport sink (input valid, input key_res, input tag_res, input last_res,
                  input overflow, output ready);
endinterface

@@ design/two_stack_bubble_sort.sv @@
// Two-stack bubble sorter. Records (signed key, tag) are taken one per cycle
// and pushed onto stack one, up to MAX_RECORDS; further records are dropped
// and the set is marked overflow. The record flagged last starts the sort of
// the n records held; the input is not ready again until the sorted set has
// left. The sort runs n passes through one key comparator; each pass first
// primes the stack's registered read port, then pops one record per cycle.
// The sorted records then leave in ascending key order, each by a read of
// the result buffer and then the output transfer, with last_res on the
// final one. The stacks need no clearing after reset.
`include "two_stack_bubble_sort_assert.svh"

module two_stack_bubble_sort
    import tsbs_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    tsbs_in_if.sink      in_ch,
    tsbs_out_if.source   out_ch
);

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_PASS,
        ST_EMIT_RD,
        ST_EMIT_SHOW
    } state_t;

    // Control state
    state_t             state_reg,     state_next;
    logic [CNT_W-1:0]   loaded_reg,    loaded_next;
    logic               dropped_reg,   dropped_next;
    logic [CNT_W-1:0]   n_reg,         n_next;
    logic [CNT_W-1:0]   src_cnt_reg,   src_cnt_next;
    logic [CNT_W-1:0]   dst_cnt_reg,   dst_cnt_next;
    logic               held_vld_reg,  held_vld_next;
    logic               sel_reg,       sel_next;
    logic [IDX_W-1:0]   emit_idx_reg,  emit_idx_next;

    // Top of the receiving stack, kept out of memory
    rec_t               held_reg,      held_next;

    // Storage
    rec_t               stack_one [MAX_RECORDS];
    rec_t               stack_two [MAX_RECORDS];
    rec_t               sorted_mem [MAX_RECORDS];
    rec_t               one_q_reg, two_q_reg, sorted_q_reg;

    logic               one_we, two_we, sorted_we;
    logic [IDX_W-1:0]   one_waddr, two_waddr, sorted_waddr;
    rec_t               one_wdata, two_wdata, sorted_wdata;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   rd_cnt;

    rec_t               rec_in;
    rec_t               src_rec;
    rec_t               dst_wdata;
    logic               dst_we;
    logic               top_gt;
    logic [CNT_W-1:0]   dst_cnt_upd;
    rec_t               held_upd;
    logic               emit_last;

    assign rec_in    = '{key: in_ch.key, tag: in_ch.tag};
    assign src_rec   = sel_reg ? two_q_reg : one_q_reg;
    assign top_gt    = held_reg.key > src_rec.key;
    assign emit_last = CNT_W'(emit_idx_reg) == (n_reg - CNT_W'(1));

    // Prime reads the current top; during a pass, prefetch the entry below it
    assign rd_cnt  = (state_reg == ST_PASS) ? (src_cnt_reg - CNT_W'(2))
                                            : (src_cnt_reg - CNT_W'(1));
    assign rd_addr = rd_cnt[IDX_W-1:0];

    // Ports
    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = (state_reg == ST_EMIT_SHOW);
    assign out_ch.key_res  = sorted_q_reg.key;
    assign out_ch.tag_res  = sorted_q_reg.tag;
    assign out_ch.last_res = emit_last;
    assign out_ch.overflow = dropped_reg;

    // Pop step: lift the held top over a smaller record, else push on top
    always_comb
    begin
        dst_we      = 1'b0;
        dst_wdata   = held_reg;
        held_upd    = src_rec;
        dst_cnt_upd = dst_cnt_reg;
        if (held_vld_reg)
        begin
            dst_we      = 1'b1;
            dst_cnt_upd = dst_cnt_reg + CNT_W'(1);
            if (top_gt)
            begin
                dst_wdata = src_rec;
                held_upd  = held_reg;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        dropped_next  = dropped_reg;
        n_next        = n_reg;
        src_cnt_next  = src_cnt_reg;
        dst_cnt_next  = dst_cnt_reg;
        held_vld_next = held_vld_reg;
        sel_next      = sel_reg;
        emit_idx_next = emit_idx_reg;
        held_next     = held_reg;

        one_we        = 1'b0;
        one_waddr     = dst_cnt_reg[IDX_W-1:0];
        one_wdata     = dst_wdata;
        two_we        = 1'b0;
        two_waddr     = dst_cnt_reg[IDX_W-1:0];
        two_wdata     = dst_wdata;
        sorted_we     = 1'b0;
        sorted_waddr  = dst_cnt_upd[IDX_W-1:0];
        sorted_wdata  = held_upd;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    // Load: push onto stack one or drop past capacity
                    if (loaded_reg < CNT_W'(MAX_RECORDS))
                    begin
                        one_we      = 1'b1;
                        one_waddr   = loaded_reg[IDX_W-1:0];
                        one_wdata   = rec_in;
                        loaded_next = loaded_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (in_ch.last)
                    begin
                        n_next        = loaded_next;
                        src_cnt_next  = loaded_next;
                        dst_cnt_next  = '0;
                        held_vld_next = 1'b0;
                        sel_next      = 1'b0;
                        state_next    = ST_PRIME;
                    end
                end
            end

            ST_PRIME:
            begin
                state_next = ST_PASS;
            end

            ST_PASS:
            begin
                // Drive the receiving stack's write port
                if (sel_reg)
                begin
                    one_we = dst_we;
                end
                else
                begin
                    two_we = dst_we;
                end
                held_next     = held_upd;
                held_vld_next = 1'b1;
                dst_cnt_next  = dst_cnt_upd;
                src_cnt_next  = src_cnt_reg - CNT_W'(1);
                if (src_cnt_reg == CNT_W'(1))
                begin
                    // End of pass: the held top fills the next slot from the end
                    sorted_we     = 1'b1;
                    src_cnt_next  = dst_cnt_upd;
                    dst_cnt_next  = '0;
                    held_vld_next = 1'b0;
                    sel_next      = !sel_reg;
                    if (dst_cnt_upd == '0)
                    begin
                        emit_idx_next = '0;
                        state_next    = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_PRIME;
                    end
                end
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_SHOW;
            end

            ST_EMIT_SHOW:
            begin
                if (out_ch.ready)
                begin
                    if (emit_last)
                    begin
                        loaded_next  = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            loaded_reg   <= '0;
            dropped_reg  <= 1'b0;
            n_reg        <= '0;
            src_cnt_reg  <= '0;
            dst_cnt_reg  <= '0;
            held_vld_reg <= 1'b0;
            sel_reg      <= 1'b0;
            emit_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            dropped_reg  <= dropped_next;
            n_reg        <= n_next;
            src_cnt_reg  <= src_cnt_next;
            dst_cnt_reg  <= dst_cnt_next;
            held_vld_reg <= held_vld_next;
            sel_reg      <= sel_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    // Held record is payload only
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    // Stack one: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (one_we)
        begin
            stack_one[one_waddr] <= one_wdata;
        end
        one_q_reg <= stack_one[rd_addr];
    end

    // Stack two: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (two_we)
        begin
            stack_two[two_waddr] <= two_wdata;
        end
        two_q_reg <= stack_two[rd_addr];
    end

    // Result buffer, read in ascending order
    always_ff @(posedge clk)
    begin
        if (sorted_we)
        begin
            sorted_mem[sorted_waddr] <= sorted_wdata;
        end
        sorted_q_reg <= sorted_mem[emit_idx_reg];
    end

    `TSBS_ASSERT_IMP(a_emit_in_range, clk, rst_n, out_ch.valid,
        CNT_W'(emit_idx_reg) < n_reg, "emit index beyond record count")
    `TSBS_ASSERT_IMP(a_pass_conserves, clk, rst_n, state_reg == ST_PASS,
        (SUM_W'(src_cnt_reg) + SUM_W'(dst_cnt_reg) + SUM_W'(held_vld_reg))
            <= SUM_W'(n_reg), "records created during a pass")
    `TSBS_ASSERT_IMP(a_held_below, clk, rst_n,
        (state_reg == ST_PASS) && (dst_cnt_reg != '0), held_vld_reg,
        "receiving stack filled without a held top")
    `TSBS_ASSERT_NXT(a_set_cleared, clk, rst_n,
        out_ch.valid && out_ch.ready && out_ch.last_res,
        (loaded_reg == '0) && !dropped_reg && in_ch.ready, "set not cleared after emission")

endmodule
